>>> rtl/prp_pkg.sv
// ----------------------------------------------------------------------------
// prp_pkg: shared types and constants of the page replacement policy block
// Field widths of the channels, policy codes, datapath commands and status.
// ----------------------------------------------------------------------------
package prp_pkg;

   // channel field widths
   localparam int PAGE_W       = 16;
   localparam int COUNT_W      = 3;
   localparam int POLICY_W     = 2;
   localparam int RECENT_PORTS = 4;

   typedef logic [POLICY_W-1:0] policy_type;

   // policy register codes; the unused code falls back to FIFO
   localparam policy_type POLICY_FIFO  = 2'd0;
   localparam policy_type POLICY_LRU   = 2'd1;
   localparam policy_type POLICY_CLOCK = 2'd2;

   // commands from the controller to the datapath
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_LOOKUP,
      CMD_HIT,
      CMD_FILL,
      CMD_SWEEP,
      CMD_EVICT,
      CMD_NOTE,
      CMD_RESULT
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic hit;
      logic full;
      logic sweep_busy;
      logic out_free;
   } status_type;

endpackage

>>> rtl/prp_if.sv
// ----------------------------------------------------------------------------
// prp_if: channel interfaces of the page replacement policy block
// Request (page reference), response (lookup result) and register write.
// ----------------------------------------------------------------------------

// page reference channel
interface prp_req_if;
   logic                         valid;
   logic                         ready;
   logic [prp_pkg::PAGE_W-1:0]   page;

   modport source (output valid, output page, input ready);
   modport sink   (input valid, input page, output ready);
endinterface

// result channel
interface prp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic                         victim_valid;
   logic [prp_pkg::PAGE_W-1:0]   victim_page;
   logic [prp_pkg::COUNT_W-1:0]  frames_used;
   logic [prp_pkg::COUNT_W-1:0]  recent_count;
   logic [prp_pkg::PAGE_W-1:0]   recent_0;
   logic [prp_pkg::PAGE_W-1:0]   recent_1;
   logic [prp_pkg::PAGE_W-1:0]   recent_2;
   logic [prp_pkg::PAGE_W-1:0]   recent_3;

   modport source (output valid, output hit, output victim_valid, output victim_page,
                   output frames_used, output recent_count, output recent_0,
                   output recent_1, output recent_2, output recent_3, input ready);
   modport sink   (input valid, input hit, input victim_valid, input victim_page,
                   input frames_used, input recent_count, input recent_0,
                   input recent_1, input recent_2, input recent_3, output ready);
endinterface

// policy register write channel
interface prp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [prp_pkg::POLICY_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/prp_controller.sv
// ----------------------------------------------------------------------------
// prp_controller: sequencer of the page replacement policy block
// Steps one item through lookup, update, optional clock sweep, victim list
// update and result write, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module prp_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  prp_pkg::status_type  status,
   output prp_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_NOTE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   // command and next state
   always_comb begin
      cmd      = prp_pkg::CMD_NONE;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd      = prp_pkg::CMD_ACCEPT;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd      = prp_pkg::CMD_LOOKUP;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            priority if (status.hit) begin
               cmd      = prp_pkg::CMD_HIT;
               state_in = ST_DONE;
            end else if (!status.full) begin
               cmd      = prp_pkg::CMD_FILL;
               state_in = ST_DONE;
            end else if (status.sweep_busy) begin
               // clear one reference bit and move the hand
               cmd      = prp_pkg::CMD_SWEEP;
            end else begin
               cmd      = prp_pkg::CMD_EVICT;
               state_in = ST_NOTE;
            end
         end
         ST_NOTE: begin
            cmd      = prp_pkg::CMD_NOTE;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to drain
            if (status.out_free) begin
               cmd      = prp_pkg::CMD_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign in_ready = ready_ff;

endmodule

>>> rtl/prp_datapath.sv
// ----------------------------------------------------------------------------
// prp_datapath: frame store, replacement state and result register
// Executes the controller's commands: parallel hit compare, recency update,
// fill, FIFO / LRU / clock eviction, recent victim list and result write.
// ----------------------------------------------------------------------------
module prp_datapath #(
   parameter int FRAMES       = 4,
   parameter int PAGE_BITS    = 16,
   parameter int RECENT_DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  prp_pkg::cmd_type            cmd,
   output prp_pkg::status_type         status,
   input  logic [prp_pkg::PAGE_W-1:0]  in_page,
   prp_csr_if.sink                     csr_chan,
   prp_rsp_if.source                   rsp_chan
);

   localparam int IDX_W  = $clog2(FRAMES);
   localparam int FILL_W = $clog2(FRAMES + 1);
   localparam int RCNT_W = $clog2(RECENT_DEPTH + 1);
   localparam int RIDX_W = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;

   // replacement state
   logic [PAGE_BITS-1:0]     frames_ff [FRAMES];
   logic [FILL_W-1:0]        filled_ff;
   logic [IDX_W-1:0]         rank_ff [FRAMES];
   logic [IDX_W-1:0]         rank_in [FRAMES];
   logic [FRAMES-1:0]        ref_ff;
   logic [IDX_W-1:0]         fifo_ff;
   logic [IDX_W-1:0]         hand_ff;
   logic [PAGE_BITS-1:0]     recent_ff [RECENT_DEPTH];
   logic [RCNT_W-1:0]        rcount_ff;
   prp_pkg::policy_type      policy_ff;

   // per item registers
   logic [PAGE_BITS-1:0]     page_ff;
   logic                     hit_ff;
   logic [IDX_W-1:0]         hit_idx_ff;
   logic [PAGE_BITS-1:0]     victim_ff;
   logic                     vvalid_ff;

   // result register
   logic                         rsp_valid_ff;
   logic                         out_hit_ff;
   logic                         out_vvalid_ff;
   logic [prp_pkg::PAGE_W-1:0]   out_victim_ff;
   logic [prp_pkg::COUNT_W-1:0]  out_frames_ff;
   logic [prp_pkg::COUNT_W-1:0]  out_rcount_ff;
   logic [prp_pkg::PAGE_W-1:0]   out_recent_ff [prp_pkg::RECENT_PORTS];
   logic [prp_pkg::PAGE_W-1:0]   recent_view [prp_pkg::RECENT_PORTS];

   logic [31:0]              in_wide;
   logic [31:0]              victim_wide;
   logic [31:0]              filled_wide;
   logic [31:0]              rcount_wide;

   logic                     hit_now;
   logic [IDX_W-1:0]         hit_idx_now;
   logic [IDX_W-1:0]         lru_idx;
   logic [FRAMES-1:0]        rank_zero;
   logic [IDX_W-1:0]         fill_slot;
   logic [IDX_W-1:0]         evict_slot;
   logic [IDX_W-1:0]         fifo_next;
   logic [IDX_W-1:0]         hand_next;
   logic                     touch_en;
   logic [IDX_W-1:0]         touch_idx;
   logic [IDX_W-1:0]         touch_old;
   logic                     full;
   logic                     out_free;
   logic                     rmatch;
   logic [RIDX_W-1:0]        ridx;
   logic                     is_lru;
   logic                     is_clock;

   assign in_wide     = 32'(in_page);
   assign victim_wide = 32'(victim_ff);
   assign filled_wide = 32'(filled_ff);
   assign rcount_wide = 32'(rcount_ff);

   assign is_lru    = (policy_ff == prp_pkg::POLICY_LRU);
   assign is_clock  = (policy_ff == prp_pkg::POLICY_CLOCK);
   assign full      = (filled_ff == FILL_W'(FRAMES));
   assign fill_slot = filled_ff[IDX_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   // hit compare over the filled frames, lowest index wins
   always_comb begin
      hit_now     = 1'b0;
      hit_idx_now = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if ((FILL_W'(i) < filled_ff) && (frames_ff[i] == page_ff)) begin
            hit_now     = 1'b1;
            hit_idx_now = IDX_W'(i);
         end
      end
   end

   // least recent frame holds rank zero; ranks form a permutation
   always_comb begin
      lru_idx = '0;
      for (int i = 0; i < FRAMES; i++) begin
         rank_zero[i] = (rank_ff[i] == '0);
         if (rank_zero[i]) begin
            lru_idx = IDX_W'(i);
         end
      end
   end

   // pointer wrap
   assign fifo_next = (fifo_ff == IDX_W'(FRAMES - 1)) ? '0 : fifo_ff + 1'b1;
   assign hand_next = (hand_ff == IDX_W'(FRAMES - 1)) ? '0 : hand_ff + 1'b1;

   // eviction slot by policy
   always_comb begin
      priority if (is_lru) begin
         evict_slot = lru_idx;
      end else if (is_clock) begin
         evict_slot = hand_ff;
      end else begin
         evict_slot = fifo_ff;
      end
   end

   // recency touch select
   always_comb begin
      touch_en  = 1'b0;
      touch_idx = '0;
      unique case (cmd)
         prp_pkg::CMD_HIT: begin
            touch_en  = 1'b1;
            touch_idx = hit_idx_ff;
         end
         prp_pkg::CMD_FILL: begin
            touch_en  = is_lru;
            touch_idx = fill_slot;
         end
         prp_pkg::CMD_EVICT: begin
            touch_en  = is_lru;
            touch_idx = lru_idx;
         end
         default: touch_en = 1'b0;
      endcase
   end

   // touched frame becomes most recent, newer frames age by one
   assign touch_old = rank_ff[touch_idx];
   always_comb begin
      for (int j = 0; j < FRAMES; j++) begin
         if (IDX_W'(j) == touch_idx) begin
            rank_in[j] = IDX_W'(FRAMES - 1);
         end else if (rank_ff[j] > touch_old) begin
            rank_in[j] = rank_ff[j] - 1'b1;
         end else begin
            rank_in[j] = rank_ff[j];
         end
      end
   end

   // recent list entry equal to the loaded page, lowest index wins
   always_comb begin
      rmatch = 1'b0;
      ridx   = '0;
      for (int i = RECENT_DEPTH - 1; i >= 0; i--) begin
         if ((RCNT_W'(i) < rcount_ff) && (recent_ff[i] == page_ff)) begin
            rmatch = 1'b1;
            ridx   = RIDX_W'(i);
         end
      end
   end

   // list view for the result, entries beyond the count read as zero
   for (genvar k = 0; k < prp_pkg::RECENT_PORTS; k++) begin : g_view
      if (k < RECENT_DEPTH) begin : g_entry
         logic [31:0] entry_wide;
         assign entry_wide     = 32'(recent_ff[k]);
         assign recent_view[k] = (RCNT_W'(k) < rcount_ff) ?
                                 entry_wide[prp_pkg::PAGE_W-1:0] : '0;
      end else begin : g_none
         assign recent_view[k] = '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff    <= '0;
         ref_ff       <= '0;
         fifo_ff      <= '0;
         hand_ff      <= '0;
         rcount_ff    <= '0;
         policy_ff    <= prp_pkg::POLICY_FIFO;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         vvalid_ff    <= 1'b0;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= IDX_W'(i);
         end
      end else begin
         if (csr_chan.valid) begin
            policy_ff <= csr_chan.data;
         end
         if (touch_en) begin
            rank_ff <= rank_in;
         end
         // result register handshake, a new write wins over a drain
         if (cmd == prp_pkg::CMD_RESULT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd)
            prp_pkg::CMD_LOOKUP: begin
               hit_ff    <= hit_now;
               vvalid_ff <= 1'b0;
            end
            prp_pkg::CMD_HIT: begin
               ref_ff[hit_idx_ff] <= 1'b1;
            end
            prp_pkg::CMD_FILL: begin
               filled_ff <= filled_ff + 1'b1;
               if (is_clock) begin
                  ref_ff[fill_slot] <= 1'b1;
               end
            end
            prp_pkg::CMD_SWEEP: begin
               ref_ff[hand_ff] <= 1'b0;
               hand_ff         <= hand_next;
            end
            prp_pkg::CMD_EVICT: begin
               vvalid_ff <= 1'b1;
               if (is_clock) begin
                  ref_ff[evict_slot] <= 1'b1;
               end else if (!is_lru) begin
                  fifo_ff <= fifo_next;
               end
            end
            prp_pkg::CMD_NOTE: begin
               if (!rmatch && (rcount_ff < RCNT_W'(RECENT_DEPTH))) begin
                  rcount_ff <= rcount_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (cmd)
         prp_pkg::CMD_ACCEPT: begin
            page_ff <= in_wide[PAGE_BITS-1:0];
         end
         prp_pkg::CMD_LOOKUP: begin
            hit_idx_ff <= hit_idx_now;
         end
         prp_pkg::CMD_FILL: begin
            frames_ff[fill_slot] <= page_ff;
         end
         prp_pkg::CMD_EVICT: begin
            victim_ff             <= frames_ff[evict_slot];
            frames_ff[evict_slot] <= page_ff;
         end
         prp_pkg::CMD_NOTE: begin
            if (rmatch) begin
               recent_ff[ridx] <= victim_ff;
            end else begin
               for (int i = 1; i < RECENT_DEPTH; i++) begin
                  recent_ff[i] <= recent_ff[i-1];
               end
               recent_ff[0] <= victim_ff;
            end
         end
         prp_pkg::CMD_RESULT: begin
            out_hit_ff    <= hit_ff;
            out_vvalid_ff <= vvalid_ff;
            out_victim_ff <= vvalid_ff ? victim_wide[prp_pkg::PAGE_W-1:0] : '0;
            out_frames_ff <= filled_wide[prp_pkg::COUNT_W-1:0];
            out_rcount_ff <= rcount_wide[prp_pkg::COUNT_W-1:0];
            out_recent_ff <= recent_view;
         end
         default: ;
      endcase
   end

   // status to the controller
   assign status.hit        = hit_ff;
   assign status.full       = full;
   assign status.sweep_busy = is_clock && ref_ff[hand_ff];
   assign status.out_free   = out_free;

   // ports
   assign csr_chan.ready        = 1'b1;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.hit          = out_hit_ff;
   assign rsp_chan.victim_valid = out_vvalid_ff;
   assign rsp_chan.victim_page  = out_victim_ff;
   assign rsp_chan.frames_used  = out_frames_ff;
   assign rsp_chan.recent_count = out_rcount_ff;
   assign rsp_chan.recent_0     = out_recent_ff[0];
   assign rsp_chan.recent_1     = out_recent_ff[1];
   assign rsp_chan.recent_2     = out_recent_ff[2];
   assign rsp_chan.recent_3     = out_recent_ff[3];

`ifndef ASSERT_OFF
   // exactly one frame is least recent at all times
   a_rank_perm: assert property (@(posedge clock) disable iff (reset)
      $onehot(rank_zero))
      else $error("recency ranks lost their permutation");

   // fill count and list count stay in range
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      (filled_ff <= FILL_W'(FRAMES)) && (rcount_ff <= RCNT_W'(RECENT_DEPTH)))
      else $error("fill or list count out of range");

   // a result is only written into a free output register
   a_result_free: assert property (@(posedge clock) disable iff (reset)
      (cmd == prp_pkg::CMD_RESULT) |-> out_free)
      else $error("result written over a pending item");

   // an eviction only happens with every frame filled
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (cmd == prp_pkg::CMD_EVICT) |-> (full && !hit_ff))
      else $error("eviction without a full store");
`endif

endmodule

>>> rtl/page_replacement_policy.sv
// ----------------------------------------------------------------------------
// page_replacement_policy: FIFO / LRU / clock page replacement engine
// Each item passes accept, lookup, update, a victim list note after an eviction
// and result write; under clock the hand first clears set reference bits it
// passes (<= FRAMES). Next item accepted in the cycle after the result write.
// Synchronous reset empties the store, ranks frames by index, policy FIFO.
// ----------------------------------------------------------------------------
module page_replacement_policy #(
   parameter int FRAMES       = 4,
   parameter int PAGE_BITS    = 16,
   parameter int RECENT_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   prp_req_if.sink     req_chan,
   prp_rsp_if.source   rsp_chan,
   prp_csr_if.sink     csr_chan
);

   prp_pkg::cmd_type     cmd;
   prp_pkg::status_type  status;
   logic                 in_ready;

   // sequencer
   prp_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (in_ready),
      .status   (status),
      .cmd      (cmd)
   );

   // frame store and replacement state
   prp_datapath #(
      .FRAMES       (FRAMES),
      .PAGE_BITS    (PAGE_BITS),
      .RECENT_DEPTH (RECENT_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .in_page  (req_chan.page),
      .csr_chan (csr_chan),
      .rsp_chan (rsp_chan)
   );

   assign req_chan.ready = in_ready;

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the page replacement policy block
// Page references go in through the request channel under each replacement
// policy in turn. An in-bench model of the frame store predicts every lookup
// result, and each returned result is checked field by field against it.
// ----------------------------------------------------------------------------
module testbench;

   localparam int FRAMES       = 4;
   localparam int RECENT_DEPTH = 4;
   localparam int PHASE_ITEMS  = 143;
   localparam int MAX_PRINTS   = 200;
   localparam int PAGE_W       = prp_pkg::PAGE_W;
   localparam int COUNT_W      = prp_pkg::COUNT_W;
   localparam int RECENT_PORTS = prp_pkg::RECENT_PORTS;

   // the unused register code, which must act as FIFO
   localparam prp_pkg::policy_type POLICY_SPARE = 2'd3;

   // one lookup result as the block should report it
   typedef struct {
      logic                hit;
      logic                victim_valid;
      logic [PAGE_W-1:0]   victim_page;
      logic [COUNT_W-1:0]  frames_used;
      logic [COUNT_W-1:0]  recent_count;
      logic [PAGE_W-1:0]   recent [RECENT_PORTS];
   } lookup_type;

   logic clock;
   logic reset;

   prp_req_if req_bus ();
   prp_rsp_if rsp_bus ();
   prp_csr_if csr_bus ();

   page_replacement_policy uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // pages waiting to be sent, and lookups waiting to come back
   logic [PAGE_W-1:0] reference_queue [$];
   lookup_type        predicted_lookups [$];

   int mismatch_count;
   bit quiet;

   // frame store model
   prp_pkg::policy_type policy_setting;
   logic [PAGE_W-1:0]   frame_page [FRAMES];
   int unsigned         frame_rank [FRAMES];
   bit                  ref_bit [FRAMES];
   int unsigned         frames_filled;
   int unsigned         fifo_ptr;
   int unsigned         clock_hand;
   logic [PAGE_W-1:0]   evicted_list [RECENT_DEPTH];
   int unsigned         evicted_count;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // make frame f the most recent, closing the gap it leaves
   function automatic void promote_frame(int unsigned f);
      int unsigned old_rank;
      old_rank = frame_rank[f];
      for (int j = 0; j < FRAMES; j++)
         if (j != f && frame_rank[j] > old_rank)
            frame_rank[j]--;
      frame_rank[f] = FRAMES - 1;
   endfunction

   // apply one page reference to the model and return the lookup result
   function automatic lookup_type predict_lookup(logic [PAGE_W-1:0] page);
      lookup_type  r;
      int unsigned slot;
      bit          replaced;
      r.hit          = 1'b0;
      r.victim_valid = 1'b0;
      r.victim_page  = '0;
      slot           = 0;

      // parallel hit check over the filled frames
      for (int i = 0; i < frames_filled; i++)
         if (!r.hit && frame_page[i] == page) begin
            r.hit = 1'b1;
            promote_frame(i);
            ref_bit[i] = 1'b1;
         end

      if (!r.hit) begin
         if (frames_filled < FRAMES) begin
            // empty frames fill in index order
            frame_page[frames_filled] = page;
            if (policy_setting == prp_pkg::POLICY_LRU)
               promote_frame(frames_filled);
            else if (policy_setting == prp_pkg::POLICY_CLOCK)
               ref_bit[frames_filled] = 1'b1;
            frames_filled++;
         end else begin
            // victim selection
            if (policy_setting == prp_pkg::POLICY_LRU) begin
               for (int j = 1; j < FRAMES; j++)
                  if (frame_rank[j] < frame_rank[slot])
                     slot = j;
               promote_frame(slot);
            end else if (policy_setting == prp_pkg::POLICY_CLOCK) begin
               while (ref_bit[clock_hand]) begin
                  ref_bit[clock_hand] = 1'b0;
                  clock_hand = (clock_hand + 1) % FRAMES;
               end
               slot = clock_hand;
               ref_bit[slot] = 1'b1;
            end else begin
               slot = fifo_ptr;
               fifo_ptr = (fifo_ptr + 1) % FRAMES;
            end
            r.victim_valid   = 1'b1;
            r.victim_page    = frame_page[slot];
            frame_page[slot] = page;

            // recent victims: overwrite the entry equal to the loaded page,
            // else shift in at the front
            replaced = 1'b0;
            for (int i = 0; i < evicted_count; i++)
               if (!replaced && evicted_list[i] == page) begin
                  evicted_list[i] = r.victim_page;
                  replaced = 1'b1;
               end
            if (!replaced) begin
               for (int i = RECENT_DEPTH - 1; i > 0; i--)
                  evicted_list[i] = evicted_list[i-1];
               evicted_list[0] = r.victim_page;
               if (evicted_count < RECENT_DEPTH)
                  evicted_count++;
            end
         end
      end

      r.frames_used  = COUNT_W'(frames_filled);
      r.recent_count = COUNT_W'(evicted_count);
      for (int i = 0; i < RECENT_PORTS; i++)
         r.recent[i] = (i < evicted_count) ? evicted_list[i] : '0;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [PAGE_W-1:0] got,
                                  logic [PAGE_W-1:0] want);
      if (mismatch_count < MAX_PRINTS)
         $display("tb: mismatch %0t %s: got %h expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // wait until nothing is queued, in flight or expected; checked once the
   // edge's updates have settled, then realigned to a rising edge
   task automatic wait_idle();
      do @(negedge clock);
      while (reference_queue.size() != 0 || req_bus.valid || predicted_lookups.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_policy(prp_pkg::policy_type code);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= code;
      do @(posedge clock);
      while (!(csr_bus.valid && csr_bus.ready));
      policy_setting = code;
      csr_bus.valid <= 1'b0;
   endtask

   // request driver: holds an item until taken, idles in random bursts
   always @(posedge clock) begin : reference_driver
      int idle_left;
      if (reset) begin
         req_bus.valid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predicted_lookups.push_back(predict_lookup(req_bus.page));
            if (!quiet && $urandom_range(0, 4) == 0)
               idle_left = $urandom_range(1, 11);
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the current item
         end else if (idle_left > 0) begin
            idle_left--;
            req_bus.valid <= 1'b0;
         end else if (reference_queue.size() != 0) begin
            req_bus.valid <= 1'b1;
            req_bus.page  <= reference_queue.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result monitor: checks each item taken, stalls in random bursts
   always @(posedge clock) begin : result_monitor
      lookup_type want;
      int         stall_left;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_lookups.size() == 0) begin
               report_mismatch("unexpected item", '0, '0);
            end else begin
               want = predicted_lookups.pop_front();
               if (rsp_bus.hit !== want.hit)
                  report_mismatch("hit", rsp_bus.hit, want.hit);
               if (rsp_bus.victim_valid !== want.victim_valid)
                  report_mismatch("victim_valid", rsp_bus.victim_valid, want.victim_valid);
               if (rsp_bus.victim_page !== want.victim_page)
                  report_mismatch("victim_page", rsp_bus.victim_page, want.victim_page);
               if (rsp_bus.frames_used !== want.frames_used)
                  report_mismatch("frames_used", rsp_bus.frames_used, want.frames_used);
               if (rsp_bus.recent_count !== want.recent_count)
                  report_mismatch("recent_count", rsp_bus.recent_count, want.recent_count);
               if (rsp_bus.recent_0 !== want.recent[0])
                  report_mismatch("recent_0", rsp_bus.recent_0, want.recent[0]);
               if (rsp_bus.recent_1 !== want.recent[1])
                  report_mismatch("recent_1", rsp_bus.recent_1, want.recent[1]);
               if (rsp_bus.recent_2 !== want.recent[2])
                  report_mismatch("recent_2", rsp_bus.recent_2, want.recent[2]);
               if (rsp_bus.recent_3 !== want.recent[3])
                  report_mismatch("recent_3", rsp_bus.recent_3, want.recent[3]);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 6) == 0)
               stall_left = $urandom_range(1, 11);
         end
      end
   end

   // stimulus: directed references, then random phases under each policy
   initial begin : stimulus
      prp_pkg::policy_type phase_policy [9];
      logic [PAGE_W-1:0]   pool [8];
      int                  pool_size;
      logic [PAGE_W-1:0]   page;

      phase_policy = '{prp_pkg::POLICY_LRU, prp_pkg::POLICY_CLOCK, POLICY_SPARE,
                       prp_pkg::POLICY_FIFO, prp_pkg::POLICY_CLOCK, prp_pkg::POLICY_LRU,
                       prp_pkg::POLICY_CLOCK, prp_pkg::POLICY_FIFO, prp_pkg::POLICY_LRU};

      clock          = 1'b0;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.page   = '0;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.data   = prp_pkg::POLICY_FIFO;
      quiet          = 1'b0;
      mismatch_count = 0;

      // model state after reset
      policy_setting = prp_pkg::POLICY_FIFO;
      frames_filled  = 0;
      fifo_ptr       = 0;
      clock_hand     = 0;
      evicted_count  = 0;
      for (int i = 0; i < FRAMES; i++) begin
         frame_page[i] = '0;
         frame_rank[i] = i;
         ref_bit[i]    = 1'b0;
      end
      for (int i = 0; i < RECENT_DEPTH; i++)
         evicted_list[i] = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed, reset policy FIFO: fill, hit, evict, reload of a recent victim
      reference_queue = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'hFFFF,
                          16'h0001, 16'h0000, 16'h5555, 16'h8000, 16'h0001,
                          16'hFFFF, 16'h7FFF, 16'h0000, 16'h1234, 16'h8000};
      wait_idle();

      for (int p = 0; p < 9; p++) begin
         write_policy(phase_policy[p]);
         quiet = (p == 8) || ($urandom_range(0, 3) == 0);

         // short directed burst at each policy change: 0000, FFFF, then 0000 again
         reference_queue.push_back(16'h0000);
         reference_queue.push_back(16'hFFFF);
         reference_queue.push_back(16'h0000);

         // working-set references with some fully random pages
         pool_size = $urandom_range(3, 8);
         for (int i = 0; i < pool_size; i++)
            pool[i] = PAGE_W'($urandom);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 19) == 0)
               pool[$urandom_range(0, pool_size - 1)] = PAGE_W'($urandom);
            if ($urandom_range(0, 9) < 8)
               page = pool[$urandom_range(0, pool_size - 1)];
            else
               page = PAGE_W'($urandom);
            reference_queue.push_back(page);
         end
         wait_idle();
      end

      // settle before judging
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && predicted_lookups.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
